FILE: hdl/ikp_pkg.sv
`timescale 1ns / 1ps
package ikp_pkg;
   localparam int PATH_BYTES = 256;
   localparam int DOC_BYTES = 65536;
   localparam int PATH_AW = $clog2(PATH_BYTES);
   localparam int PATH_CW = PATH_AW + 1;
   localparam int IDX_W = 18;
   localparam logic [15:0] POS_MAX = (DOC_BYTES - 1 > 65535) ? 16'hFFFF : 16'(DOC_BYTES - 1);

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [1:0] STATUS_FOUND = 2'd0;
   localparam logic [1:0] STATUS_INDENT = 2'd1;
   localparam logic [1:0] STATUS_NONE = 2'd2;

   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_DASH,
      CLS_COLON,
      CLS_EOL,
      CLS_ZERO,
      CLS_OTHER
   } byte_class_type;

   typedef enum logic [2:0] {
      M_SPACE,
      M_KEY,
      M_KEYSEP,
      M_VALUE,
      M_NEWLINE
   } scan_mode_type;

   typedef enum logic {
      PH_ISSUE,
      PH_EVAL
   } phase_type;

   typedef struct packed {
      logic           operation;
      byte_class_type cls;
      logic [7:0]     data_byte;
      logic           last;
   } item_type;
endpackage

FILE: hdl/ikp_req_if.sv
`timescale 1ns / 1ps
interface ikp_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output operation, output data_byte, output last,
                   input ready);
   modport sink (input valid, input operation, input data_byte, input last,
                 output ready);
endinterface

FILE: hdl/ikp_rsp_if.sv
`timescale 1ns / 1ps
interface ikp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] value_offset;
   logic [15:0] value_length;

   modport source (output valid, output status, output value_offset, output value_length,
                   input ready);
   modport sink (input valid, input status, input value_offset, input value_length,
                 output ready);
endinterface

FILE: hdl/ikp_ram.sv
`timescale 1ns / 1ps
module ikp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

FILE: hdl/ikp_front.sv
`timescale 1ns / 1ps
module ikp_front (
   input  logic              clock,
   input  logic              reset,
   ikp_req_if.sink           req,
   output ikp_pkg::item_type q_item,
   output logic              q_valid,
   input  logic              q_pop
);
   import ikp_pkg::*;

   item_type       entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;
   item_type       new_item;
   byte_class_type cls;

   always_comb begin
      if (req.data_byte == 8'd0) begin
         cls = CLS_ZERO;
      end else if (req.data_byte == CH_SPACE) begin
         cls = CLS_SPACE;
      end else if (req.data_byte == CH_DASH) begin
         cls = CLS_DASH;
      end else if (req.data_byte == CH_COLON) begin
         cls = CLS_COLON;
      end else if (req.data_byte == CH_LF || req.data_byte == CH_CR) begin
         cls = CLS_EOL;
      end else begin
         cls = CLS_OTHER;
      end
      new_item.operation = req.operation;
      new_item.cls = cls;
      new_item.data_byte = req.data_byte;
      new_item.last = req.last;
   end

   assign req.ready = (count_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule

FILE: hdl/ikp_back.sv
`timescale 1ns / 1ps
module ikp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ikp_pkg::item_type            q_item,
   input  logic                         q_valid,
   output logic                         q_pop,
   output logic                         ram_wr_en,
   output logic [ikp_pkg::PATH_AW-1:0]  ram_wr_addr,
   output logic [7:0]                   ram_wr_data,
   output logic [ikp_pkg::PATH_AW-1:0]  ram_rd_addr_a,
   input  logic [7:0]                   ram_rd_data_a,
   output logic [ikp_pkg::PATH_AW-1:0]  ram_rd_addr_b,
   input  logic [7:0]                   ram_rd_data_b,
   ikp_rsp_if.source                    rsp
);
   import ikp_pkg::*;

   phase_type          phase_ff, phase_in;
   item_type           item_ff;
   logic [PATH_AW-1:0] addr_a_ff, addr_b_ff;
   logic               a_lt_ff, b_lt_ff;

   scan_mode_type      mode_ff, mode_in;
   logic [PATH_CW-1:0] path_count_ff, path_count_in;
   logic [PATH_CW-1:0] cursor_ff, cursor_in;
   logic [15:0]        li_ff, li_in;
   logic [15:0]        mi_ff, mi_in;
   logic [15:0]        kc_ff, kc_in;
   logic [15:0]        vc_ff, vc_in;
   logic [15:0]        vstart_ff, vstart_in;
   logic [15:0]        pos_ff, pos_in;
   logic               fkey_ff, fkey_in;
   logic               fvprev_ff, fvprev_in;
   logic               fvlast_ff, fvlast_in;
   logic               fcolon_ff, fcolon_in;
   logic               brace_ok_ff, brace_ok_in;
   logic               answered_ff, answered_in;

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic [15:0]        out_offset_ff, out_offset_in;
   logic [15:0]        out_length_ff, out_length_in;

   logic               slot_free, capture, exec;
   logic [IDX_W-1:0]   bi, vb, va;
   logic               pa, pa_brace, b_open, b_end;
   logic               emit, vmatch, found;
   logic [IDX_W-1:0]   cur;

   assign slot_free = !out_valid_ff || rsp.ready;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_ISSUE: if (q_valid && q_item.operation) phase_in = PH_EVAL;
         PH_EVAL: if (slot_free) phase_in = PH_ISSUE;
         default: phase_in = PH_ISSUE;
      endcase
   end

   always_comb begin
      q_pop = (phase_ff == PH_ISSUE) && q_valid;
      capture = q_pop && q_item.operation;
      exec = (phase_ff == PH_EVAL) && slot_free;
      ram_wr_en = q_pop && !q_item.operation && (q_item.data_byte != 8'd0)
                  && (path_count_ff < PATH_CW'(PATH_BYTES));
   end

   assign ram_wr_addr = path_count_ff[PATH_AW-1:0];
   assign ram_wr_data = q_item.data_byte;

   always_comb begin
      bi = IDX_W'(cursor_ff) + IDX_W'(kc_ff);
      vb = bi + IDX_W'(1) + IDX_W'(vc_ff);
      if ((mode_ff == M_VALUE || mode_ff == M_KEYSEP) && q_item.cls != CLS_EOL) begin
         va = vb + IDX_W'(fcolon_ff);
      end else begin
         va = bi;
      end
   end

   assign ram_rd_addr_a = (phase_ff == PH_ISSUE) ? va[PATH_AW-1:0] : addr_a_ff;
   assign ram_rd_addr_b = (phase_ff == PH_ISSUE) ? vb[PATH_AW-1:0] : addr_b_ff;

   always_comb begin
      pa = a_lt_ff && (ram_rd_data_a == item_ff.data_byte);
      pa_brace = a_lt_ff && (ram_rd_data_a == CH_LBRACE);
      b_open = b_lt_ff && (ram_rd_data_b != CH_RBRACE);
      b_end = !b_lt_ff || (ram_rd_data_b == CH_RBRACE);

      mode_in = mode_ff;
      path_count_in = path_count_ff;
      cursor_in = cursor_ff;
      li_in = li_ff;
      mi_in = mi_ff;
      kc_in = kc_ff;
      vc_in = vc_ff;
      vstart_in = vstart_ff;
      pos_in = pos_ff;
      fkey_in = fkey_ff;
      fvprev_in = fvprev_ff;
      fvlast_in = fvlast_ff;
      fcolon_in = fcolon_ff;
      brace_ok_in = brace_ok_ff;
      answered_in = answered_ff;
      emit = 1'b0;
      out_status_in = out_status_ff;
      out_offset_in = out_offset_ff;
      out_length_in = out_length_ff;
      vmatch = 1'b0;
      found = 1'b0;
      cur = '0;

      if (ram_wr_en) begin
         path_count_in = path_count_ff + PATH_CW'(1);
      end

      if (exec) begin
         if (!answered_ff) begin
            if (item_ff.cls == CLS_ZERO) begin
               emit = 1'b1;
               out_status_in = STATUS_NONE;
               out_offset_in = '0;
               out_length_in = '0;
               answered_in = 1'b1;
            end else begin
               case (item_ff.cls)
                  CLS_SPACE, CLS_DASH: begin
                     if (mode_ff == M_NEWLINE || mode_ff == M_SPACE) begin
                        mode_in = M_SPACE;
                        li_in = (li_ff == 16'hFFFF) ? li_ff : li_ff + 16'd1;
                     end else if (mode_ff == M_KEY) begin
                        if (!pa) fkey_in = 1'b0;
                        kc_in = (kc_ff == 16'hFFFF) ? kc_ff : kc_ff + 16'd1;
                     end else if (mode_ff == M_VALUE ||
                                  (mode_ff == M_KEYSEP && item_ff.cls == CLS_DASH)) begin
                        if (mode_ff == M_KEYSEP) begin
                           mode_in = M_VALUE;
                           vstart_in = pos_ff;
                           fcolon_in = 1'b0;
                        end
                        if (mode_ff == M_VALUE && !fvlast_ff) fvprev_in = 1'b0;
                        if (mode_ff == M_KEYSEP) fvprev_in = 1'b1;
                        fvlast_in = pa;
                        brace_ok_in = (mode_ff == M_KEYSEP) ? b_open : (brace_ok_ff && b_open);
                        vc_in = (vc_ff == 16'hFFFF) ? vc_ff : vc_ff + 16'd1;
                     end
                  end
                  CLS_COLON: begin
                     if (mode_ff == M_KEY) begin
                        mode_in = M_KEYSEP;
                        if (!pa) fkey_in = 1'b0;
                        kc_in = (kc_ff == 16'hFFFF) ? kc_ff : kc_ff + 16'd1;
                     end else if (mode_ff == M_KEYSEP) begin
                        mode_in = M_VALUE;
                        vstart_in = pos_ff;
                        vc_in = '0;
                        fvprev_in = 1'b1;
                        fvlast_in = pa;
                        fcolon_in = 1'b1;
                        brace_ok_in = 1'b1;
                     end else if (mode_ff == M_VALUE) begin
                        if (!fvlast_ff) fvprev_in = 1'b0;
                        fvlast_in = pa;
                        brace_ok_in = brace_ok_ff && b_open;
                        vc_in = (vc_ff == 16'hFFFF) ? vc_ff : vc_ff + 16'd1;
                     end
                  end
                  CLS_EOL: begin
                     if (mode_ff != M_NEWLINE) begin
                        if (li_ff < mi_ff) begin
                           emit = 1'b1;
                           out_status_in = STATUS_INDENT;
                           out_offset_in = '0;
                           out_length_in = '0;
                           answered_in = 1'b1;
                        end else if (kc_ff != 16'd0 && fkey_ff) begin
                           vmatch = fcolon_ff ? fvprev_ff : (fvprev_ff && fvlast_ff);
                           found = pa_brace ? (brace_ok_ff && b_end && vmatch) : 1'b1;
                           cur = bi + (pa_brace ? (IDX_W'(vc_ff) + IDX_W'(2)) : '0);
                           if (cur > IDX_W'(path_count_ff)) cur = IDX_W'(path_count_ff);
                           if (found) begin
                              cursor_in = cur[PATH_CW-1:0];
                              mi_in = li_ff;
                              if (cur >= IDX_W'(path_count_ff)) begin
                                 emit = 1'b1;
                                 out_status_in = STATUS_FOUND;
                                 out_offset_in = vstart_ff;
                                 out_length_in = vc_ff;
                                 answered_in = 1'b1;
                              end
                           end
                        end
                        li_in = '0;
                        kc_in = '0;
                        vc_in = '0;
                        fkey_in = 1'b1;
                        fvprev_in = 1'b1;
                        fvlast_in = 1'b1;
                        fcolon_in = 1'b0;
                        brace_ok_in = 1'b1;
                     end
                     mode_in = M_NEWLINE;
                  end
                  default: begin
                     if (mode_ff == M_SPACE || mode_ff == M_NEWLINE || mode_ff == M_KEY) begin
                        mode_in = M_KEY;
                        if (!pa || (mode_ff != M_KEY ? 1'b0 : !fkey_ff)) fkey_in = 1'b0;
                        else fkey_in = 1'b1;
                        kc_in = (mode_ff != M_KEY) ? 16'd1
                              : ((kc_ff == 16'hFFFF) ? kc_ff : kc_ff + 16'd1);
                     end else begin
                        if (mode_ff == M_KEYSEP) begin
                           mode_in = M_VALUE;
                           vstart_in = pos_ff;
                           fcolon_in = 1'b0;
                           fvprev_in = 1'b1;
                        end else if (!fvlast_ff) begin
                           fvprev_in = 1'b0;
                        end
                        fvlast_in = pa;
                        brace_ok_in = (mode_ff == M_KEYSEP) ? b_open : (brace_ok_ff && b_open);
                        vc_in = (mode_ff == M_KEYSEP) ? 16'd1
                              : ((vc_ff == 16'hFFFF) ? vc_ff : vc_ff + 16'd1);
                     end
                  end
               endcase
               if (pos_ff < POS_MAX) pos_in = pos_ff + 16'd1;
            end
         end
         if (item_ff.last) begin
            if (!answered_in && !emit) begin
               emit = 1'b1;
               out_status_in = STATUS_NONE;
               out_offset_in = '0;
               out_length_in = '0;
            end
            mode_in = M_SPACE;
            path_count_in = '0;
            cursor_in = '0;
            li_in = '0;
            mi_in = '0;
            kc_in = '0;
            vc_in = '0;
            vstart_in = '0;
            pos_in = '0;
            fkey_in = 1'b1;
            fvprev_in = 1'b1;
            fvlast_in = 1'b1;
            fcolon_in = 1'b0;
            brace_ok_in = 1'b1;
            answered_in = 1'b0;
         end
      end
      out_valid_in = (out_valid_ff && !rsp.ready) || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ISSUE;
         mode_ff <= M_SPACE;
         path_count_ff <= '0;
         cursor_ff <= '0;
         li_ff <= '0;
         mi_ff <= '0;
         kc_ff <= '0;
         vc_ff <= '0;
         vstart_ff <= '0;
         pos_ff <= '0;
         fkey_ff <= 1'b1;
         fvprev_ff <= 1'b1;
         fvlast_ff <= 1'b1;
         fcolon_ff <= 1'b0;
         brace_ok_ff <= 1'b1;
         answered_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         mode_ff <= mode_in;
         path_count_ff <= path_count_in;
         cursor_ff <= cursor_in;
         li_ff <= li_in;
         mi_ff <= mi_in;
         kc_ff <= kc_in;
         vc_ff <= vc_in;
         vstart_ff <= vstart_in;
         pos_ff <= pos_in;
         fkey_ff <= fkey_in;
         fvprev_ff <= fvprev_in;
         fvlast_ff <= fvlast_in;
         fcolon_ff <= fcolon_in;
         brace_ok_ff <= brace_ok_in;
         answered_ff <= answered_in;
         out_valid_ff <= out_valid_in;
      end
      if (capture) begin
         item_ff <= q_item;
         addr_a_ff <= va[PATH_AW-1:0];
         addr_b_ff <= vb[PATH_AW-1:0];
         a_lt_ff <= va < IDX_W'(path_count_ff);
         b_lt_ff <= vb < IDX_W'(path_count_ff);
      end
      out_status_ff <= out_status_in;
      out_offset_ff <= out_offset_in;
      out_length_ff <= out_length_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.value_offset = out_offset_ff;
   assign rsp.value_length = out_length_ff;
endmodule

FILE: hdl/indented_key_path_lookup.sv
`timescale 1ns / 1ps
// Path query bytes (operation 0) and document bytes (operation 1) enter through a two-beat
// queue and are executed in order. A nonzero path byte is written into the path memory while it has room.
// A document byte takes two steps: one reads two path bytes from the dual-read path memory
// at the positions set by the cursor, key and value counts; the other updates the line
// state and, at a line end, decides the match. A result waits in an output register; while
// it waits, the engine holds the next document byte in its second step until that beat is
// taken, and the queue then fills and stalls the input.
module indented_key_path_lookup (
   input logic       clock,
   input logic       reset,
   ikp_req_if.sink   req,
   ikp_rsp_if.source rsp
);
   import ikp_pkg::*;

   item_type           q_item;
   logic               q_valid, q_pop;
   logic               ram_wr_en;
   logic [PATH_AW-1:0] ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [7:0]         ram_wr_data, ram_rd_data_a, ram_rd_data_b;

   ikp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   ikp_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_path_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   ikp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_item        (q_item),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr_a (ram_rd_addr_a),
      .ram_rd_data_a (ram_rd_data_a),
      .ram_rd_addr_b (ram_rd_addr_b),
      .ram_rd_data_b (ram_rd_data_b),
      .rsp           (rsp)
   );
endmodule

FILE: verif/ikp_checker.sv
`timescale 1ns / 1ps
// Watches both channels, predicts each answer of the lookup and compares it with the response
// beats in order.
module ikp_checker
   import ikp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ikp_req_if   req_bus,
   ikp_rsp_if   rsp_bus,
   output int   fail_count,
   output int   pending_count
);
   localparam logic [3:0] FL_KEY = 4'd1;
   localparam logic [3:0] FL_VPREV = 4'd2;
   localparam logic [3:0] FL_VLAST = 4'd4;
   localparam logic [3:0] FL_COLON = 4'd8;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] offset;
      logic [15:0] length;
   } answer_type;

   answer_type    answers[$];
   logic [7:0]    query_mem[PATH_BYTES];
   int            query_len;
   int            cursor;
   scan_mode_type mode;
   int            indent;
   int            match_level;
   int            key_len;
   int            val_len;
   int            val_begin;
   int            doc_pos;
   logic [3:0]    flags;
   bit            done;

   assign pending_count = answers.size();

   function automatic bit query_has(int idx, logic [7:0] c);
      return idx < query_len && idx < PATH_BYTES && query_mem[idx] == c;
   endfunction

   function automatic int inc16(int v);
      return v < 65535 ? v + 1 : 65535;
   endfunction

   function automatic answer_type make_answer(logic [1:0] st, int off, int len);
      answer_type a;
      a.status = st;
      a.offset = off[15:0];
      a.length = len[15:0];
      return a;
   endfunction

   task automatic clear_line();
      indent = 0;
      key_len = 0;
      val_len = 0;
      flags = FL_KEY | FL_VPREV | FL_VLAST;
   endtask

   task automatic clear_all();
      query_len = 0;
      cursor = 0;
      mode = M_SPACE;
      match_level = 0;
      val_begin = 0;
      doc_pos = 0;
      done = 0;
      clear_line();
   endtask

   task automatic note_key(logic [7:0] c);
      if (!query_has(cursor + key_len, c)) flags &= ~FL_KEY;
      key_len = inc16(key_len);
   endtask

   task automatic compare_value(logic [7:0] c, int ridx);
      bit ok;
      ok = query_has(cursor + key_len + 1 + ridx, c);
      if (!(flags & FL_VLAST)) flags &= ~FL_VPREV;
      if (ok) flags |= FL_VLAST;
      else flags &= ~FL_VLAST;
   endtask

   task automatic note_value(logic [7:0] c);
      compare_value(c, val_len + ((flags & FL_COLON) ? 1 : 0));
      val_len = inc16(val_len);
   endtask

   task automatic begin_value();
      mode = M_VALUE;
      val_begin = doc_pos;
      val_len = 0;
      flags = (flags & FL_KEY) | FL_VPREV | FL_VLAST;
   endtask

   task automatic close_line(output bit hit, output answer_type a);
      bit found;
      bit vmatch;
      int pos;
      int brace;
      int j;
      hit = 0;
      a = '0;
      if (mode != M_NEWLINE) begin
         if (indent < match_level) begin
            a = make_answer(STATUS_INDENT, 0, 0);
            done = 1;
            hit = 1;
         end else if (key_len != 0 && (flags & FL_KEY)) begin
            found = 1;
            pos = cursor;
            brace = pos + key_len;
            if (query_has(brace, CH_LBRACE)) begin
               j = brace + 1;
               while (j < query_len && j < PATH_BYTES && query_mem[j] != CH_RBRACE) j++;
               if (flags & FL_COLON) vmatch = (flags & FL_VPREV) != 0;
               else vmatch = (flags & FL_VPREV) != 0 && (flags & FL_VLAST) != 0;
               if (val_len == j - (brace + 1) && vmatch) pos += val_len + 2;
               else found = 0;
            end
            if (found) begin
               pos += key_len;
               if (pos > query_len) pos = query_len;
               cursor = pos;
               match_level = indent;
               if (pos >= query_len) begin
                  a = make_answer(STATUS_FOUND, val_begin, val_len);
                  done = 1;
                  hit = 1;
               end
            end
         end
         clear_line();
      end
      mode = M_NEWLINE;
   endtask

   task automatic scan(logic [7:0] c, output bit hit, output answer_type a);
      hit = 0;
      a = '0;
      if (c == 8'h00) begin
         a = make_answer(STATUS_NONE, 0, 0);
         done = 1;
         hit = 1;
         return;
      end
      if (c == CH_SPACE || c == CH_DASH) begin
         if (mode == M_NEWLINE) mode = M_SPACE;
         if (mode == M_SPACE) indent = inc16(indent);
         else if (mode == M_KEY) note_key(c);
         else if (mode == M_VALUE) note_value(c);
         else if (mode == M_KEYSEP && c == CH_DASH) begin
            begin_value();
            flags &= ~FL_COLON;
            note_value(c);
         end
      end else if (c == CH_COLON) begin
         if (mode == M_KEY) begin
            mode = M_KEYSEP;
            note_key(c);
         end else if (mode == M_KEYSEP) begin
            begin_value();
            flags &= ~FL_COLON;
            compare_value(c, 0);
            flags |= FL_COLON;
         end else if (mode == M_VALUE) begin
            note_value(c);
         end
      end else if (c == CH_LF || c == CH_CR) begin
         close_line(hit, a);
      end else begin
         if (mode == M_SPACE || mode == M_NEWLINE) begin
            mode = M_KEY;
            key_len = 0;
            flags |= FL_KEY;
         end else if (mode == M_KEYSEP) begin
            begin_value();
            flags &= ~FL_COLON;
         end
         if (mode == M_KEY) note_key(c);
         else if (mode == M_VALUE) note_value(c);
      end
      if (doc_pos < int'(POS_MAX)) doc_pos++;
   endtask

   task automatic predict(logic op, logic [7:0] c, logic fin);
      bit hit;
      answer_type a;
      hit = 0;
      if (!op) begin
         if (c != 8'h00 && query_len < PATH_BYTES) begin
            query_mem[query_len] = c;
            query_len++;
         end
         return;
      end
      if (!done) scan(c, hit, a);
      if (fin) begin
         if (!done && !hit) begin
            a = make_answer(STATUS_NONE, 0, 0);
            hit = 1;
         end
         clear_all();
      end
      if (hit) answers.push_back(a);
   endtask

   task automatic report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      clear_all();
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers.size() == 0) begin
               report($sformatf("unexpected result beat status %0d", rsp_bus.status));
            end else begin
               want = answers.pop_front();
               if (rsp_bus.status !== want.status)
                  report($sformatf("status %0d, expected %0d", rsp_bus.status, want.status));
               if (rsp_bus.value_offset !== want.offset)
                  report($sformatf("value_offset %0d, expected %0d", rsp_bus.value_offset,
                                   want.offset));
               if (rsp_bus.value_length !== want.length)
                  report($sformatf("value_length %0d, expected %0d", rsp_bus.value_length,
                                   want.length));
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict(req_bus.operation, req_bus.data_byte, req_bus.last);
      end
   end
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import ikp_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_count;
   int   send_idle;
   int   rsp_stall;
   int   hold_request;
   int   hold_left;
   int   sent;

   ikp_req_if req_bus ();
   ikp_rsp_if rsp_bus ();

   indented_key_path_lookup dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   ikp_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // The receiver takes beats at random; a requested hold-off keeps it stalled until the
   // hold-off count runs down.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left <= hold_request;
         hold_request <= 0;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall);
      end
   end

   task automatic send(logic op, logic [7:0] c, logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.data_byte <= c;
      req_bus.last <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_text(logic op, string s, bit fin_on_end);
      for (int i = 0; i < s.len(); i++)
         send(op, s[i], fin_on_end && i == s.len() - 1);
   endtask

   function automatic string pick_name();
      string s;
      string alpha;
      alpha = "abk";
      s = "";
      repeat ($urandom_range(1, 2)) s = {s, string'(alpha[$urandom_range(2)])};
      return s;
   endfunction

   function automatic byte unsigned noise_byte();
      byte unsigned set[8];
      set = '{8'h20, 8'h2D, 8'h3A, 8'h0A, 8'h0D, 8'h7B, 8'h7D, 8'h61};
      case ($urandom_range(9))
         0: return byte'($urandom_range(255));
         1: return 8'h00;
         default: return set[$urandom_range(7)];
      endcase
   endfunction

   task automatic run_lookup();
      string path;
      string doc;
      string pad;
      string key;
      string val;
      int    levels;
      bit    braced;
      levels = $urandom_range(1, 3);
      path = "";
      doc = "";
      for (int i = 0; i < levels; i++) begin
         key = pick_name();
         braced = $urandom_range(3) == 0;
         val = "";
         repeat ($urandom_range(0, 2)) val = {val, ($urandom_range(1) ? "x" : "y")};
         path = {path, key, ":"};
         if (braced) path = {path, "{", val, "}"};
         pad = "";
         repeat (2 * i) pad = {pad, " "};
         if (i > 0 && $urandom_range(2) == 0) pad = {pad.substr(0, pad.len() - 2), "-"};
         if ($urandom_range(3) == 0) doc = {doc, pad, pick_name(), ": q\n"};
         if (i > 0 && $urandom_range(9) == 0) doc = {doc, "z:\n"};
         doc = {doc, pad, key, ":"};
         if (braced) doc = {doc, " ", ($urandom_range(4) == 0) ? "x" : val};
         else if (i == levels - 1) doc = {doc, " ", pick_name(), ($urandom_range(1) ? ":v" : "")};
         doc = {doc, ($urandom_range(3) == 0) ? "\r" : "\n"};
      end
      if ($urandom_range(6) == 0) doc = {doc, ":", "\n"};
      send_text(1'b0, path, 0);
      if ($urandom_range(9) == 0) send(1'b0, 8'h00, 1'b1);
      for (int i = 0; i < doc.len(); i++) begin
         if ($urandom_range(29) == 0) send(1'b1, noise_byte(), 1'b0);
         else send(1'b1, doc[i], 1'b0);
      end
      send(1'b1, ($urandom_range(1) ? 8'h0A : noise_byte()), 1'b1);
   endtask

   task automatic run_noise();
      repeat ($urandom_range(3)) send(1'b0, noise_byte(), $urandom_range(1));
      repeat ($urandom_range(1, 15)) send(1'b1, noise_byte(), 1'b0);
      send(1'b1, byte'($urandom_range(255)), 1'b1);
   endtask

   initial begin
      int settings_send[4];
      int settings_stall[4];
      settings_send = '{0, 65, 0, 24};
      settings_stall = '{0, 0, 65, 24};
      req_bus.valid = 1'b0;
      req_bus.operation = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last = 1'b0;
      rsp_bus.ready = 1'b0;
      send_idle = 0;
      rsp_stall = 0;
      hold_request = 0;
      hold_left = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text(1'b0, "a:", 0);
      send_text(1'b1, "a: 1\n", 1);
      send_text(1'b0, "a:", 0);
      send_text(1'b1, "a::x\n", 1);
      send_text(1'b0, "k:{", 0);
      send_text(1'b1, "k:\n", 1);
      send(1'b0, 8'h00, 1'b1);
      send_text(1'b1, "b:\n", 1);
      send(1'b1, 8'hFF, 1'b0);
      send(1'b1, 8'h00, 1'b0);
      send(1'b1, 8'h41, 1'b1);
      repeat (300) send(1'b0, byte'($urandom_range(1, 255)), 1'b0);
      send(1'b1, 8'h0A, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle = settings_send[phase];
         rsp_stall = settings_stall[phase];
         if (phase == 0) hold_request <= 400;
         while (sent < 330 + (phase + 1) * 410) begin
            if ($urandom_range(5) == 0) run_noise();
            else run_lookup();
         end
      end
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: sim.f
hdl/ikp_pkg.sv
hdl/ikp_req_if.sv
hdl/ikp_rsp_if.sv
hdl/ikp_ram.sv
hdl/ikp_front.sv
hdl/ikp_back.sv
hdl/indented_key_path_lookup.sv
verif/ikp_checker.sv
verif/tb_top.sv
